FILE: hw/rtl/jsbn_pkg.sv
// ----------------------------------------------------------------------------
// jsbn_pkg
// Shared constants for the joystick speed bus node: the default filter
// precision, the speed limit, the joystick center and the stream widths.
// ----------------------------------------------------------------------------
package jsbn_pkg;

    // Default number of fraction bits in the speed filter.
    localparam int C_FRAC_BITS_DEF = 16;

    // Joystick center code and speed magnitude limit.
    localparam logic [7:0] C_JOY_CENTER  = 8'h80;
    localparam int         C_SPEED_LIMIT = 127;

    // Stream data widths, padded to whole bytes.
    localparam int C_IN_TDATA_W  = 24;
    localparam int C_OUT_TDATA_W = 72;

endpackage

FILE: hw/rtl/jsbn_filter.sv
// ----------------------------------------------------------------------------
// jsbn_filter
// Speed request datapath: first-order low-pass filter on the centered
// joystick deflection, clamp and truncation to a signed speed, and the
// ramp toward zero that replaces the filter while an error is reported.
// ----------------------------------------------------------------------------
module jsbn_filter #(
    parameter int FRAC_BITS = jsbn_pkg::C_FRAC_BITS_DEF
) (
    input  logic [7:0]                  i_joy,
    input  logic                        i_err,
    input  logic                        i_creep,
    input  logic signed [FRAC_BITS+7:0] i_filt,
    input  logic signed [7:0]           i_speed,
    output logic signed [FRAC_BITS+7:0] o_filt,
    output logic signed [7:0]           o_speed
);
    import jsbn_pkg::*;

    localparam int    WF      = FRAC_BITS + 8;
    localparam int    WS      = FRAC_BITS + 10;
    localparam int    WA      = 2 * FRAC_BITS + 10;
    localparam longint C_ONE  = longint'(1) << FRAC_BITS;
    localparam longint C_ALPHA_L = (C_ONE * 2 + 500) / 1000;
    localparam int    AW      = $clog2(C_ALPHA_L + 1) + 1;
    localparam int    WPF     = WF + AW;
    localparam int    WPD     = 9 + AW;

    localparam logic signed [AW-1:0] C_ALPHA = AW'(C_ALPHA_L);
    localparam logic signed [WA-1:0] C_HALF  = WA'(C_ONE / 2);
    localparam logic signed [WS-1:0] C_POS   = WS'(C_SPEED_LIMIT) <<< FRAC_BITS;
    localparam logic signed [WS-1:0] C_NEG   = -C_POS;

    logic signed [8:0]    w_dev;
    logic signed [WPF-1:0] w_prod_f;
    logic signed [WPD-1:0] w_prod_d;
    logic signed [WA-1:0] w_base;
    logic signed [WA-1:0] w_pf_ext;
    logic signed [WA-1:0] w_pd_ext;
    logic signed [WA-1:0] w_xterm;
    logic signed [WA-1:0] w_acc;
    logic signed [WA-1:0] w_shift;
    logic signed [WS-1:0] w_fs;
    logic signed [WF-1:0] w_fc;
    logic        [WF-1:0] w_mag;
    logic        [7:0]    w_int;
    logic signed [7:0]    w_spd;

    // Centered deflection and the two coefficient products.
    assign w_dev    = $signed({1'b0, i_joy}) - $signed({1'b0, C_JOY_CENTER});
    assign w_prod_f = i_filt * C_ALPHA;
    assign w_prod_d = w_dev * C_ALPHA;

    // Accumulator: f * (1 - alpha) + x * alpha (x * alpha / 4 in creep mode), plus half an LSB for rounding.
    assign w_base   = $signed({{(WA - WF){i_filt[WF-1]}}, i_filt}) <<< FRAC_BITS;
    assign w_pf_ext = $signed({{(WA - WPF){w_prod_f[WPF-1]}}, w_prod_f});
    assign w_pd_ext = $signed({{(WA - WPD){w_prod_d[WPD-1]}}, w_prod_d});
    assign w_xterm  = i_creep ? (w_pd_ext <<< (FRAC_BITS - 2)) : (w_pd_ext <<< FRAC_BITS);
    assign w_acc    = w_base - w_pf_ext + w_xterm + C_HALF;
    assign w_shift  = w_acc >>> FRAC_BITS;
    assign w_fs     = w_shift[WS-1:0];

    // Clamp to the speed limit.
    always_comb begin
        if (w_fs > C_POS) begin
            w_fc = C_POS[WF-1:0];
        end else if (w_fs < C_NEG) begin
            w_fc = C_NEG[WF-1:0];
        end else begin
            w_fc = w_fs[WF-1:0];
        end
    end

    // Integer part, truncated toward zero.
    assign w_mag = w_fc[WF-1] ? WF'(-w_fc) : WF'(w_fc);
    assign w_int = w_mag[WF-1:FRAC_BITS];
    assign w_spd = w_fc[WF-1] ? -$signed(w_int) : $signed(w_int);

    // Error freezes the filter and ramps the speed by one toward zero.
    always_comb begin
        if (i_err) begin
            o_filt = i_filt;
            if (i_speed > 8'sd0) begin
                o_speed = i_speed - 8'sd1;
            end else if (i_speed < 8'sd0) begin
                o_speed = i_speed + 8'sd1;
            end else begin
                o_speed = i_speed;
            end
        end else begin
            o_filt  = w_fc;
            o_speed = w_spd;
        end
    end

endmodule

FILE: hw/rtl/joystick_speed_bus_node.sv
// ----------------------------------------------------------------------------
// joystick_speed_bus_node
// Per-tick speed request filter and bus frame scheduler.
// ----------------------------------------------------------------------------
// One input item is one 5 ms tick: tdata holds joystick_y, peer_state and
// motor_state, tuser holds the upstream error flag. The block updates the
// speed request, advances a 2-bit tick counter and, depending on the slot,
// sends a 7-byte status frame, a speed frame, a slow frame every fourth visit
// of its slot, or nothing. Each output item is one frame descriptor.
// The item is held in an input register and all of its work is done in the
// single logic pass from that register into the result register, so a frame
// reaches the master side from the result register, and one tick can be
// accepted every cycle while the receiver keeps the result register drained.
// The input register refills while a finished frame still waits on the master
// side; when the receiver stalls and both registers are full, tready drops.
// The creep_mode register is written on the configuration channel, which is
// always ready; write it only while no ticks are in flight.
// Reset (synchronous, active low) clears the tick and slow counters, the
// filter and speed, sets node state to its initial value and creep mode on.
// ----------------------------------------------------------------------------
module joystick_speed_bus_node #(
    parameter int FRAC_BITS = jsbn_pkg::C_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Tick input.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] joystick_y, [15:8] peer_state, [23:16] motor_state
    input  logic [jsbn_pkg::C_IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] upstream_error
    input  logic                               i_s_axis_tuser,
    // Frame output.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [10:0] frame_id, [13:11] frame_length, [21:14] byte_0, [29:22] byte_1,
    // [37:30] byte_2, [45:38] byte_3, [53:46] byte_4, [61:54] byte_5,
    // [69:62] byte_6, [71:70] zero
    output logic [jsbn_pkg::C_OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Configuration: creep_mode.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data
);
    import jsbn_pkg::*;

    localparam int WF = FRAC_BITS + 8;

    // Tick slots.
    localparam logic [1:0] C_SLOT_STATUS = 2'd0;
    localparam logic [1:0] C_SLOT_SPEED  = 2'd2;
    localparam logic [1:0] C_SLOT_SLOW   = 2'd3;

    // Node and peer state codes.
    localparam logic [7:0] C_NS_START    = 8'h10;
    localparam logic [7:0] C_NS_READY    = 8'h20;
    localparam logic [7:0] C_NS_STOPPING = 8'h21;
    localparam logic [7:0] C_NS_STOPPED  = 8'h22;
    localparam logic [7:0] C_NS_ARMED    = 8'h23;
    localparam logic [7:0] C_NS_DRIVE    = 8'h25;

    // Frame constants.
    localparam logic [10:0] C_FRAME_ID   = 11'h010;
    localparam logic [7:0]  C_HDR_BYTE   = 8'hB0;
    localparam logic [7:0]  C_VAR_STATUS = 8'h01;
    localparam logic [7:0]  C_VAR_SPEED  = 8'h0B;
    localparam logic [7:0]  C_VAR_SLOW   = 8'h0E;
    localparam logic [7:0]  C_STATUS_B3  = 8'h11;
    localparam logic [7:0]  C_STATUS_B5  = 8'h0D;
    localparam logic [2:0]  C_LEN_LONG   = 3'd7;
    localparam logic [2:0]  C_LEN_SHORT  = 3'd3;

    // Registers.
    logic                          r_creep;
    logic                          r_in_valid;
    logic [7:0]                    r_in_joy;
    logic                          r_in_err;
    logic [7:0]                    r_in_peer;
    logic [7:0]                    r_in_motor;
    logic [1:0]                    r_tick_phase;
    logic [1:0]                    r_slow_phase;
    logic [7:0]                    r_node_state;
    logic signed [WF-1:0]          r_filt;
    logic signed [7:0]             r_speed;
    logic                          r_out_valid;
    logic [C_OUT_TDATA_W-1:0]      r_out_data;

    // Next values.
    logic [1:0]                    n_tick_phase;
    logic [1:0]                    n_slow_phase;
    logic [7:0]                    n_node_state;
    logic signed [WF-1:0]          n_filt;
    logic signed [7:0]             n_speed;
    logic                          n_emit;
    logic [C_OUT_TDATA_W-1:0]      n_out_data;

    logic                          w_advance;
    logic [2:0]                    w_len;
    logic [7:0]                    w_b1;
    logic [7:0]                    w_b2;
    logic [7:0]                    w_b3;
    logic [7:0]                    w_b4;
    logic [7:0]                    w_b5;

    // Handshake: the stage moves when the result register is free or drains.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // Speed filter datapath.
    jsbn_filter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_filter (
        .i_joy   (r_in_joy),
        .i_err   (r_in_err),
        .i_creep (r_creep),
        .i_filt  (r_filt),
        .i_speed (r_speed),
        .o_filt  (n_filt),
        .o_speed (n_speed)
    );

    // Slot selection, follower machine and frame contents.
    always_comb begin
        n_tick_phase = r_tick_phase + 2'd1;
        n_slow_phase = r_slow_phase;
        n_node_state = r_node_state;
        n_emit       = 1'b0;
        w_len        = C_LEN_SHORT;
        w_b1         = C_VAR_SLOW;
        w_b2         = 8'h00;
        w_b3         = 8'h00;
        w_b4         = 8'h00;
        w_b5         = 8'h00;
        case (n_tick_phase)
            C_SLOT_STATUS: begin
                case (r_node_state)
                    C_NS_START: begin
                        if (r_in_peer == C_NS_READY) n_node_state = C_NS_READY;
                    end
                    C_NS_READY: begin
                        if (r_in_peer == C_NS_ARMED) n_node_state = C_NS_ARMED;
                    end
                    C_NS_ARMED: begin
                        if (r_in_motor == C_NS_DRIVE) n_node_state = C_NS_DRIVE;
                    end
                    C_NS_DRIVE: begin
                        if (r_in_peer == C_NS_STOPPED) n_node_state = C_NS_STOPPING;
                    end
                    C_NS_STOPPING: begin
                        if (r_in_motor == C_NS_STOPPED) n_node_state = C_NS_STOPPED;
                    end
                    C_NS_STOPPED: begin
                        if (r_in_motor == C_NS_READY) n_node_state = C_NS_READY;
                    end
                    default: begin
                        n_node_state = r_node_state;
                    end
                endcase
                n_emit = 1'b1;
                w_len  = C_LEN_LONG;
                w_b1   = C_VAR_STATUS;
                w_b2   = n_node_state;
                w_b3   = C_STATUS_B3;
                w_b4   = r_in_peer;
                w_b5   = C_STATUS_B5;
            end
            C_SLOT_SPEED: begin
                n_emit = 1'b1;
                w_b1   = C_VAR_SPEED;
                w_b2   = n_speed;
            end
            C_SLOT_SLOW: begin
                n_slow_phase = r_slow_phase + 2'd1;
                n_emit       = (n_slow_phase == 2'd0);
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
        n_out_data = {2'b00, 8'h00, w_b5, w_b4, w_b3, w_b2, w_b1, C_HDR_BYTE,
                      w_len, C_FRAME_ID};
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_creep <= 1'b1;
        end else if (i_cfg_valid) begin
            r_creep <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_joy   <= i_s_axis_tdata[7:0];
            r_in_peer  <= i_s_axis_tdata[15:8];
            r_in_motor <= i_s_axis_tdata[23:16];
            r_in_err   <= i_s_axis_tuser;
        end
    end

    // Node state, updated as each tick leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_phase <= 2'd0;
            r_slow_phase <= 2'd0;
            r_node_state <= C_NS_START;
            r_filt       <= '0;
            r_speed      <= '0;
        end else if (w_advance) begin
            r_tick_phase <= n_tick_phase;
            r_slow_phase <= n_slow_phase;
            r_node_state <= n_node_state;
            r_filt       <= n_filt;
            r_speed      <= n_speed;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= n_emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && n_emit) begin
            r_out_data <= n_out_data;
        end
    end

    // A tick that lands in the speed slot always produces a speed frame.
    a_speed_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && (r_tick_phase == 2'd1)
        |=> o_m_axis_tvalid && (o_m_axis_tdata[29:22] == C_VAR_SPEED))
        else $error("speed slot did not produce a speed frame");

    // Only the status frame is long.
    a_status_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid
        |-> ((o_m_axis_tdata[13:11] == C_LEN_LONG) == (o_m_axis_tdata[29:22] == C_VAR_STATUS)))
        else $error("frame length does not match frame kind");

    // A slow frame is only sent when the slow counter wraps.
    a_slow_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[29:22] == C_VAR_SLOW)
        |-> (r_slow_phase == 2'd0))
        else $error("slow frame sent off its slot");

    // The speed request never leaves the symmetric range.
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed != -8'sd128)
        else $error("speed request out of range");

endmodule
